FILE: sv/abl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abl_pkg
// Shared types, defaults and arithmetic helpers for the ARGB alpha blender.
// ----------------------------------------------------------------------------
package abl_pkg;

    localparam logic [31:0] DEF_RED_MASK   = 32'h00FF_0000;
    localparam logic [31:0] DEF_GREEN_MASK = 32'h0000_FF00;
    localparam logic [31:0] DEF_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [4:0]  DEF_RED_SHIFT   = 5'd16;
    localparam logic [4:0]  DEF_GREEN_SHIFT = 5'd8;
    localparam logic [4:0]  DEF_BLUE_SHIFT  = 5'd0;

    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_RED_MASK   = 4'h0;
    localparam logic [ADDR_W-1:0] REG_GREEN_MASK = 4'h4;
    localparam logic [ADDR_W-1:0] REG_BLUE_MASK  = 4'h8;

    // channel layout of the destination pixel, masks already defaulted
    typedef struct packed {
        logic [31:0] mask_r;
        logic [31:0] mask_g;
        logic [31:0] mask_b;
        logic [4:0]  sh_r;
        logic [4:0]  sh_g;
        logic [4:0]  sh_b;
    } abl_cfg_t;

    // trailing zero count, binary search; zero input gives zero
    function automatic logic [4:0] trail_zeros(input logic [31:0] v);
        logic [31:0] w;
        logic [4:0]  n;
        w = v;
        n = 5'd0;
        if (w != 32'd0) begin
            if (w[15:0] == 16'd0) begin
                n = n + 5'd16;
                w = w >> 16;
            end
            if (w[7:0] == 8'd0) begin
                n = n + 5'd8;
                w = w >> 8;
            end
            if (w[3:0] == 4'd0) begin
                n = n + 5'd4;
                w = w >> 4;
            end
            if (w[1:0] == 2'd0) begin
                n = n + 5'd2;
                w = w >> 2;
            end
            if (w[0] == 1'b0) begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // floor(x / 255), exact for x below 65280 after rounding bias
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage : abl_pkg
`default_nettype wire

FILE: sv/abl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abl_cfg
// APB register file for the channel masks; keeps defaulted masks and shifts.
// ----------------------------------------------------------------------------
module abl_cfg (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [abl_pkg::ADDR_W-1:0]   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output abl_pkg::abl_cfg_t            cfg
);
    import abl_pkg::*;

    logic [31:0] red_reg;
    logic [31:0] green_reg;
    logic [31:0] blue_reg;
    abl_cfg_t    cfg_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg        <= DEF_RED_MASK;
            green_reg      <= DEF_GREEN_MASK;
            blue_reg       <= DEF_BLUE_MASK;
            cfg_reg.mask_r <= DEF_RED_MASK;
            cfg_reg.mask_g <= DEF_GREEN_MASK;
            cfg_reg.mask_b <= DEF_BLUE_MASK;
            cfg_reg.sh_r   <= DEF_RED_SHIFT;
            cfg_reg.sh_g   <= DEF_GREEN_SHIFT;
            cfg_reg.sh_b   <= DEF_BLUE_SHIFT;
        end else if (wr_en) begin
            case (paddr)
                REG_RED_MASK: begin
                    red_reg <= pwdata;
                    if (pwdata == 32'd0) begin
                        cfg_reg.mask_r <= DEF_RED_MASK;
                        cfg_reg.sh_r   <= DEF_RED_SHIFT;
                    end else begin
                        cfg_reg.mask_r <= pwdata;
                        cfg_reg.sh_r   <= trail_zeros(pwdata);
                    end
                end
                REG_GREEN_MASK: begin
                    green_reg <= pwdata;
                    if (pwdata == 32'd0) begin
                        cfg_reg.mask_g <= DEF_GREEN_MASK;
                        cfg_reg.sh_g   <= DEF_GREEN_SHIFT;
                    end else begin
                        cfg_reg.mask_g <= pwdata;
                        cfg_reg.sh_g   <= trail_zeros(pwdata);
                    end
                end
                REG_BLUE_MASK: begin
                    blue_reg <= pwdata;
                    if (pwdata == 32'd0) begin
                        cfg_reg.mask_b <= DEF_BLUE_MASK;
                        cfg_reg.sh_b   <= DEF_BLUE_SHIFT;
                    end else begin
                        cfg_reg.mask_b <= pwdata;
                        cfg_reg.sh_b   <= trail_zeros(pwdata);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_RED_MASK:   prdata = red_reg;
            REG_GREEN_MASK: prdata = green_reg;
            REG_BLUE_MASK:  prdata = blue_reg;
            default:        prdata = 32'd0;
        endcase
    end

endmodule : abl_cfg
`default_nettype wire

FILE: sv/argb_pixel_alpha_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argb_pixel_alpha_blend
// Source-over compositing of one ARGB source pixel into a packed destination.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless a stalled output backs up into s_ready;
// the five register stages (alpha product, alpha rounding and channel
// extraction, channel products, channel division, repacking) each hold one
// pixel, and every stage with a free slot or a moving successor advances, so
// a stalled output only holds back the stages behind it once they fill up.
// Mask registers sit at 0x0, 0x4 and 0x8 and should be written while no
// pixel is in flight.
module argb_pixel_alpha_blend (
    input  wire                        aclk,
    input  wire                        aresetn,
    // configuration
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [abl_pkg::ADDR_W-1:0] paddr,
    input  wire  [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // source items
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_kind,
    input  wire  [31:0]                s_src_argb,
    input  wire  [7:0]                 s_object_alpha,
    input  wire  [31:0]                s_dst_pixel,
    // result items
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [31:0]                m_out_pixel,
    output logic                       m_write_enable
);
    import abl_pkg::*;

    localparam logic [1:0] OP_SKIP  = 2'd0;
    localparam logic [1:0] OP_COPY  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;
    localparam logic [15:0] FULL_PRODUCT = 16'd65025;

    abl_cfg_t cfg;

    abl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage valids and advance enables
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic en_a, en_b, en_c, en_d, en_e;

    assign en_e    = !ve_reg || m_ready;
    assign en_d    = !vd_reg || en_e;
    assign en_c    = !vc_reg || en_d;
    assign en_b    = !vb_reg || en_c;
    assign en_a    = !va_reg || en_b;
    assign s_ready = en_a;
    assign m_valid = ve_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= s_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
            if (en_d) vd_reg <= vc_reg;
            if (en_e) ve_reg <= vd_reg;
        end
    end

    // stage a: alpha product
    logic        kind_a_reg;
    logic [31:0] src_a_reg;
    logic [31:0] dst_a_reg;
    logic [15:0] prod_a_reg;

    always_ff @(posedge aclk) begin
        if (en_a) begin
            kind_a_reg <= s_kind;
            src_a_reg  <= s_src_argb;
            dst_a_reg  <= s_dst_pixel;
            prod_a_reg <= {8'd0, s_src_argb[31:24]} * {8'd0, s_object_alpha};
        end
    end

    // stage b: effective alpha, operation, destination channels
    logic [7:0]  alpha_b_next;
    logic [1:0]  op_b_next;
    logic [31:0] ext_r, ext_g, ext_b;
    logic [1:0]  op_b_reg;
    logic [7:0]  alpha_b_reg;
    logic [31:0] src_b_reg;
    logic [31:0] dst_b_reg;
    logic [7:0]  dr_b_reg, dg_b_reg, db_b_reg;

    always_comb begin
        if (kind_a_reg) begin
            alpha_b_next = div255(prod_a_reg + 16'd127);
        end else begin
            alpha_b_next = src_a_reg[31:24];
        end
        // a zero alpha in either mode means nothing gets written
        if (kind_a_reg && prod_a_reg == FULL_PRODUCT) begin
            op_b_next = OP_COPY;
        end else if (alpha_b_next == 8'd0) begin
            op_b_next = OP_SKIP;
        end else begin
            op_b_next = OP_BLEND;
        end
        ext_r = (dst_a_reg & cfg.mask_r) >> cfg.sh_r;
        ext_g = (dst_a_reg & cfg.mask_g) >> cfg.sh_g;
        ext_b = (dst_a_reg & cfg.mask_b) >> cfg.sh_b;
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            op_b_reg    <= op_b_next;
            alpha_b_reg <= alpha_b_next;
            src_b_reg   <= src_a_reg;
            dst_b_reg   <= dst_a_reg;
            dr_b_reg    <= ext_r[7:0];
            dg_b_reg    <= ext_g[7:0];
            db_b_reg    <= ext_b[7:0];
        end
    end

    // stage c: channel products
    logic [7:0]  inv_alpha;
    logic [1:0]  op_c_reg;
    logic [31:0] src_c_reg;
    logic [31:0] dst_c_reg;
    logic [15:0] sr_c_reg, sg_c_reg, sb_c_reg;
    logic [15:0] dr_c_reg, dg_c_reg, db_c_reg;

    assign inv_alpha = 8'd255 - alpha_b_reg;

    always_ff @(posedge aclk) begin
        if (en_c) begin
            op_c_reg  <= op_b_reg;
            src_c_reg <= src_b_reg;
            dst_c_reg <= dst_b_reg;
            sr_c_reg  <= {8'd0, src_b_reg[23:16]} * {8'd0, alpha_b_reg};
            sg_c_reg  <= {8'd0, src_b_reg[15:8]} * {8'd0, alpha_b_reg};
            sb_c_reg  <= {8'd0, src_b_reg[7:0]} * {8'd0, alpha_b_reg};
            dr_c_reg  <= {8'd0, dr_b_reg} * {8'd0, inv_alpha};
            dg_c_reg  <= {8'd0, dg_b_reg} * {8'd0, inv_alpha};
            db_c_reg  <= {8'd0, db_b_reg} * {8'd0, inv_alpha};
        end
    end

    // stage d: rounded divide by 255; an alpha of 255 reproduces the source
    logic [1:0]  op_d_reg;
    logic [31:0] src_d_reg;
    logic [31:0] dst_d_reg;
    logic [7:0]  r_d_reg, g_d_reg, b_d_reg;

    always_ff @(posedge aclk) begin
        if (en_d) begin
            op_d_reg  <= op_c_reg;
            src_d_reg <= src_c_reg;
            dst_d_reg <= dst_c_reg;
            r_d_reg   <= div255(sr_c_reg + dr_c_reg + 16'd127);
            g_d_reg   <= div255(sg_c_reg + dg_c_reg + 16'd127);
            b_d_reg   <= div255(sb_c_reg + db_c_reg + 16'd127);
        end
    end

    // stage e: repack blends into the destination layout; copies pass the source with full alpha, skips the destination
    logic [31:0] pix_e_next;
    logic        we_e_next;
    logic [31:0] packed_pix;
    logic [31:0] pix_e_reg;
    logic        we_e_reg;

    assign packed_pix = ({24'd0, r_d_reg} << cfg.sh_r)
                      | ({24'd0, g_d_reg} << cfg.sh_g)
                      | ({24'd0, b_d_reg} << cfg.sh_b);

    always_comb begin
        case (op_d_reg)
            OP_COPY: begin
                pix_e_next = {8'hFF, src_d_reg[23:0]};
                we_e_next  = 1'b1;
            end
            OP_BLEND: begin
                pix_e_next = packed_pix;
                we_e_next  = 1'b1;
            end
            default: begin
                pix_e_next = dst_d_reg;
                we_e_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en_e) begin
            pix_e_reg <= pix_e_next;
            we_e_reg  <= we_e_next;
        end
    end

    assign m_out_pixel    = pix_e_reg;
    assign m_write_enable = we_e_reg;

endmodule : argb_pixel_alpha_blend
`default_nettype wire
